// ===== design/acpf_pkg.sv =====
package acpf_pkg;

	localparam logic [7:0]  PREAMBLE_HI    = 8'h55;
	localparam logic [7:0]  PREAMBLE_LO    = 8'hAA;
	localparam logic [15:0] CRC16_POLY     = 16'h1021;
	localparam logic [15:0] CRC16_INIT     = 16'hFFFF;
	localparam logic [4:0]  CRC5_POLY      = 5'h05;
	localparam logic [4:0]  CRC5_INIT      = 5'h1F;
	localparam logic [7:0]  JOB_MASK_RESET = 8'h20;
	localparam logic [7:0]  JOB_LEN_EXTRA  = 8'd4;
	localparam logic [7:0]  CMD_LEN_EXTRA  = 8'd3;

	// both running checksums travel together
	typedef struct packed {
		logic [15:0] crc16;
		logic [4:0]  crc5;
	} crc_state_t;

	localparam crc_state_t CRC_STATE_INIT = '{crc16: CRC16_INIT, crc5: CRC5_INIT};

	// position of a byte inside the frame
	typedef enum logic [2:0] {
		SLOT_PRE_HI,
		SLOT_PRE_LO,
		SLOT_HEADER,
		SLOT_LENGTH,
		SLOT_PAYLOAD,
		SLOT_CRC_A,
		SLOT_CRC_B
	} slot_t;

endpackage

// ===== design/acpf_if.sv =====
interface acpf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic [7:0] payload_length;
	logic [7:0] payload_byte;
	logic       first_of_packet;
	logic       last_of_packet;

	modport source (
		output valid, header_byte, payload_length, payload_byte,
		       first_of_packet, last_of_packet,
		input  ready
	);
	modport sink (
		input  valid, header_byte, payload_length, payload_byte,
		       first_of_packet, last_of_packet,
		output ready
	);
endinterface

interface acpf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       end_of_frame;

	modport source (
		output valid, frame_byte, end_of_frame,
		input  ready
	);
	modport sink (
		input  valid, frame_byte, end_of_frame,
		output ready
	);
endinterface

// ===== design/acpf_crc_step.sv =====
// one byte into both checksums, msb first
module acpf_crc_step (
	input  acpf_pkg::crc_state_t crc_cur,
	input  logic [7:0]           data_byte,
	output acpf_pkg::crc_state_t crc_nxt
);

	logic [15:0] c16;
	logic [4:0]  c5;
	logic        fb;

	always_comb begin
		c16 = crc_cur.crc16 ^ {data_byte, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c16[15]) begin
				c16 = {c16[14:0], 1'b0} ^ acpf_pkg::CRC16_POLY;
			end else begin
				c16 = {c16[14:0], 1'b0};
			end
		end
		c5 = crc_cur.crc5;
		fb = 1'b0;
		for (int k = 7; k >= 0; k--) begin
			fb = c5[4] ^ data_byte[k];
			c5 = {c5[3:0], 1'b0} ^ (fb ? acpf_pkg::CRC5_POLY : 5'h00);
		end
		crc_nxt.crc16 = c16;
		crc_nxt.crc5  = c5;
	end

endmodule

// ===== design/asic_command_packet_framer_top.sv =====
// Byte framer for the serial command/job link of a hashing chip. Each input beat carries one
// payload byte; the beat flagged first_of_packet also carries the header and payload length
// and makes the block send 0x55 0xAA, the header and a length byte ahead of the payload byte.
// A packet whose header hits job_type_mask (written through cfg_wr_en/cfg_wr_data, reset 0x20)
// is a job: length byte is payload_length+4 and it ends with a CRC-16/CCITT-FALSE, high byte
// first. Any other packet is a command: length+3 and one byte holding a 5-bit CRC. The CRC
// covers header, length and payload and follows the beat flagged last_of_packet; end_of_frame
// marks the final CRC byte. The output runs one byte per cycle while the receiver is ready; a
// middle payload beat becomes 1 frame byte, a first beat 5, a last beat 2 (command) or 3 (job),
// and a one-beat packet 6 or 7. The single sequencer stage expands each beat into frame bytes.
// Both checksums are updated for the whole beat at input accept time, so a new beat can enter
// in the same cycle that the previous one hands over its final byte. An output register
// holds the frame byte, but the downstream ready reaches cmd_in.ready combinationally.
module asic_command_packet_framer_top (
	input  logic               clk,
	input  logic               arst_n,
	acpf_in_if.sink            cmd_in,
	acpf_out_if.source         frame_out,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data
);

	// configuration and packet state
	logic                 [7:0] job_type_mask_q;
	logic                       packet_is_job_q;
	acpf_pkg::crc_state_t       crc_acc_q;

	// accept side
	logic                       in_fire;
	logic                       hdr_is_job;
	logic                       item_is_job;
	logic                 [7:0] len_byte;
	acpf_pkg::crc_state_t       crc_hdr;
	acpf_pkg::crc_state_t       crc_len;
	acpf_pkg::crc_state_t       crc_pre;
	acpf_pkg::crc_state_t       crc_post;

	// sequencer stage
	logic                       valid_s1;
	acpf_pkg::slot_t            slot_s1;
	acpf_pkg::slot_t            end_slot_s1;
	logic                 [7:0] header_s1;
	logic                 [7:0] len_s1;
	logic                 [7:0] payload_s1;
	logic                       job_s1;
	acpf_pkg::crc_state_t       crc_s1;
	logic                       last_slot;
	logic                       emit;
	logic                 [7:0] emit_byte;
	logic                       emit_eof;

	// output register
	logic                       out_valid_q;
	logic                 [7:0] out_byte_q;
	logic                       out_eof_q;
	logic                       out_load_ok;

	assign in_fire = cmd_in.valid && cmd_in.ready;

	// packet type is taken fresh on a first beat, otherwise carried over
	assign hdr_is_job  = |(cmd_in.header_byte & job_type_mask_q);
	assign item_is_job = cmd_in.first_of_packet ? hdr_is_job : packet_is_job_q;
	assign len_byte    = cmd_in.payload_length +
		(item_is_job ? acpf_pkg::JOB_LEN_EXTRA : acpf_pkg::CMD_LEN_EXTRA);

	// header restarts from the initial value, length and payload continue the chain
	acpf_crc_step u_crc_hdr (
		.crc_cur   (acpf_pkg::CRC_STATE_INIT),
		.data_byte (cmd_in.header_byte),
		.crc_nxt   (crc_hdr)
	);

	acpf_crc_step u_crc_len (
		.crc_cur   (crc_hdr),
		.data_byte (len_byte),
		.crc_nxt   (crc_len)
	);

	assign crc_pre = cmd_in.first_of_packet ? crc_len : crc_acc_q;

	acpf_crc_step u_crc_pay (
		.crc_cur   (crc_pre),
		.data_byte (cmd_in.payload_byte),
		.crc_nxt   (crc_post)
	);

	// handshake: take a new beat when the stage is empty or hands over its last byte now
	assign out_load_ok  = !out_valid_q || frame_out.ready;
	assign last_slot    = (slot_s1 == end_slot_s1);
	assign emit         = valid_s1 && out_load_ok;
	assign cmd_in.ready = !valid_s1 || (out_load_ok && last_slot);

	// config register and running packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_type_mask_q <= acpf_pkg::JOB_MASK_RESET;
			packet_is_job_q <= 1'b0;
			crc_acc_q       <= acpf_pkg::CRC_STATE_INIT;
		end else begin
			if (cfg_wr_en) begin
				job_type_mask_q <= cfg_wr_data;
			end
			if (in_fire) begin
				packet_is_job_q <= item_is_job;
				// checksums return to the initial value when a last beat is taken
				crc_acc_q       <= cmd_in.last_of_packet ? acpf_pkg::CRC_STATE_INIT : crc_post;
			end
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			slot_s1     <= acpf_pkg::SLOT_PRE_HI;
			end_slot_s1 <= acpf_pkg::SLOT_PAYLOAD;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
			slot_s1  <= cmd_in.first_of_packet ? acpf_pkg::SLOT_PRE_HI : acpf_pkg::SLOT_PAYLOAD;
			if (!cmd_in.last_of_packet) begin
				end_slot_s1 <= acpf_pkg::SLOT_PAYLOAD;
			end else if (item_is_job) begin
				end_slot_s1 <= acpf_pkg::SLOT_CRC_B;
			end else begin
				end_slot_s1 <= acpf_pkg::SLOT_CRC_A;
			end
		end else if (emit) begin
			if (last_slot) begin
				valid_s1 <= 1'b0;
			end else begin
				slot_s1 <= acpf_pkg::slot_t'(slot_s1 + 3'd1);
			end
		end
	end

	// sequencer payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			header_s1  <= cmd_in.header_byte;
			len_s1     <= len_byte;
			payload_s1 <= cmd_in.payload_byte;
			job_s1     <= item_is_job;
			crc_s1     <= crc_post;
		end
	end

	// byte select for the current slot
	always_comb begin
		emit_eof = 1'b0;
		case (slot_s1)
			acpf_pkg::SLOT_PRE_HI:  emit_byte = acpf_pkg::PREAMBLE_HI;
			acpf_pkg::SLOT_PRE_LO:  emit_byte = acpf_pkg::PREAMBLE_LO;
			acpf_pkg::SLOT_HEADER:  emit_byte = header_s1;
			acpf_pkg::SLOT_LENGTH:  emit_byte = len_s1;
			acpf_pkg::SLOT_PAYLOAD: emit_byte = payload_s1;
			acpf_pkg::SLOT_CRC_A: begin
				// job: crc16 high byte, command: the whole 5-bit crc and frame end
				if (job_s1) begin
					emit_byte = crc_s1.crc16[15:8];
				end else begin
					emit_byte = {3'b000, crc_s1.crc5};
					emit_eof  = 1'b1;
				end
			end
			acpf_pkg::SLOT_CRC_B: begin
				emit_byte = crc_s1.crc16[7:0];
				emit_eof  = 1'b1;
			end
			default:                emit_byte = payload_s1;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_ok) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_eof_q  <= emit_eof;
		end
	end

	assign frame_out.valid        = out_valid_q;
	assign frame_out.frame_byte   = out_byte_q;
	assign frame_out.end_of_frame = out_eof_q;

endmodule

// ===== design/acpf_checker.sv =====
module acpf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_first,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_eof
);

	logic in_fire;

	assign in_fire = in_valid && in_ready;

	// output stays quiet while reset is applied
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_eof))
		else $error("stalled output beat changed");

	// a packet start sends four bytes ahead of its payload
	a_first_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_first |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input taken during frame preamble");

	// a packet end sends at least one crc byte after its payload
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_last |=> !in_ready)
		else $error("input taken before crc was sent");

endmodule

bind asic_command_packet_framer_top acpf_checker u_acpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd_in.valid),
	.in_ready  (cmd_in.ready),
	.in_first  (cmd_in.first_of_packet),
	.in_last   (cmd_in.last_of_packet),
	.out_valid (frame_out.valid),
	.out_ready (frame_out.ready),
	.out_byte  (frame_out.frame_byte),
	.out_eof   (frame_out.end_of_frame)
);

// ===== sim/acpf_frame_checker.sv =====
module acpf_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	acpf_in_if         cmd_ch,
	acpf_out_if        frame_ch,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	output int         fail_count,
	output int         bytes_owed,
	output int         bytes_checked,
	output int         job_frames,
	output int         cmd_frames
);

	typedef struct packed {
		logic [7:0] fbyte;
		logic       eof;
	} frame_beat_t;

	localparam int PRINT_CAP = 40;

	frame_beat_t          owed_q[$];
	frame_beat_t          want_beat;
	logic [7:0]           job_mask;
	logic                 is_job;
	acpf_pkg::crc_state_t crc;

	// one byte through both checksums, msb first
	function automatic acpf_pkg::crc_state_t crc_absorb(acpf_pkg::crc_state_t s,
			logic [7:0] b);
		logic [15:0] c16;
		logic [4:0]  c5;
		logic        fb;
		integer      k;
		c16 = s.crc16 ^ {b, 8'h00};
		for (k = 0; k < 8; k++)
			c16 = c16[15] ? ({c16[14:0], 1'b0} ^ acpf_pkg::CRC16_POLY) : {c16[14:0], 1'b0};
		c5 = s.crc5;
		for (k = 7; k >= 0; k--) begin
			fb = c5[4] ^ b[k];
			c5 = {c5[3:0], 1'b0};
			if (fb)
				c5 = c5 ^ acpf_pkg::CRC5_POLY;
		end
		return '{crc16: c16, crc5: c5};
	endfunction

	task automatic owe(logic [7:0] b, logic eof);
		owed_q.push_back('{fbyte: b, eof: eof});
	endtask

	task automatic frame_command_beat(logic [7:0] hdr, logic [7:0] plen, logic [7:0] pb,
			logic first, logic last);
		logic [7:0] len_byte;
		if (first) begin
			is_job   = (hdr & job_mask) != 8'h00;
			len_byte = plen + (is_job ? acpf_pkg::JOB_LEN_EXTRA : acpf_pkg::CMD_LEN_EXTRA);
			crc      = acpf_pkg::CRC_STATE_INIT;
			owe(acpf_pkg::PREAMBLE_HI, 1'b0);
			owe(acpf_pkg::PREAMBLE_LO, 1'b0);
			owe(hdr, 1'b0);
			owe(len_byte, 1'b0);
			crc = crc_absorb(crc, hdr);
			crc = crc_absorb(crc, len_byte);
		end
		owe(pb, 1'b0);
		crc = crc_absorb(crc, pb);
		if (last) begin
			if (is_job) begin
				owe(crc.crc16[15:8], 1'b0);
				owe(crc.crc16[7:0], 1'b1);
				job_frames++;
			end else begin
				owe({3'b000, crc.crc5}, 1'b1);
				cmd_frames++;
			end
			crc = acpf_pkg::CRC_STATE_INIT;
		end
	endtask

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		if (fail_count < PRINT_CAP)
			$display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			job_mask      = acpf_pkg::JOB_MASK_RESET;
			is_job        = 1'b0;
			crc           = acpf_pkg::CRC_STATE_INIT;
			fail_count    = 0;
			bytes_owed    = 0;
			bytes_checked = 0;
			job_frames    = 0;
			cmd_frames    = 0;
		end else begin
			// output side first: a byte can never come from a beat taken at the same edge
			if (frame_ch.valid && frame_ch.ready) begin
				bytes_checked++;
				if (owed_q.size() == 0) begin
					report_mismatch("frame byte with nothing owed", frame_ch.frame_byte, 8'h00);
				end else begin
					want_beat = owed_q.pop_front();
					if (frame_ch.frame_byte !== want_beat.fbyte)
						report_mismatch("frame_byte", frame_ch.frame_byte, want_beat.fbyte);
					if (frame_ch.end_of_frame !== want_beat.eof)
						report_mismatch("end_of_frame", {7'b0, frame_ch.end_of_frame},
							{7'b0, want_beat.eof});
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				frame_command_beat(cmd_ch.header_byte, cmd_ch.payload_length,
					cmd_ch.payload_byte, cmd_ch.first_of_packet, cmd_ch.last_of_packet);
			if (cfg_wr_en)
				job_mask = cfg_wr_data;
			bytes_owed = owed_q.size();
		end
	end

endmodule

// ===== sim/tb_asic_command_packet_framer_top.sv =====
module tb_asic_command_packet_framer_top;

	// random beats per mask setting, roughly 380 over the whole run
	localparam int RANDOM_BEATS_PER_PHASE = 54;
	localparam int NUM_PHASES             = 6;
	// worst legit quiet stretch is a sender gap plus a long receiver stall
	localparam int IDLE_LIMIT             = 4000;
	// output register plus sequencer depth, with margin
	localparam int DRAIN_CYCLES           = 24;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_BURSTY
	} rx_mode_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	int fail_count;
	int bytes_owed;
	int bytes_checked;
	int job_frames;
	int cmd_frames;
	int beats_sent;
	int burst_left;
	int idle_cycles;
	int settings_used;

	acpf_in_if  cmd_in();
	acpf_out_if frame_out();

	asic_command_packet_framer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_in      (cmd_in),
		.frame_out   (frame_out),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// predicts every frame byte from the accepted beats and compares
	acpf_frame_checker frame_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_ch        (cmd_in),
		.frame_ch      (frame_out),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (fail_count),
		.bytes_owed    (bytes_owed),
		.bytes_checked (bytes_checked),
		.job_frames    (job_frames),
		.cmd_frames    (cmd_frames)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// byte with extra weight on all-zero and all-one
	function automatic logic [7:0] random_byte();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// one input beat; sender works in bursts with idle gaps between them
	task automatic send_beat(input logic [7:0] hdr, input logic [7:0] plen,
			input logic [7:0] pb, input logic first, input logic last);
		logic took;
		int   gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				cmd_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then a long stretch with no idling at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 16);
		end
		burst_left--;
		cmd_in.valid           <= 1'b1;
		cmd_in.header_byte     <= hdr;
		cmd_in.payload_length  <= plen;
		cmd_in.payload_byte    <= pb;
		cmd_in.first_of_packet <= first;
		cmd_in.last_of_packet  <= last;
		// ready is sampled mid-cycle, where it holds its value for the coming edge
		do begin
			@(negedge clk);
			took = cmd_in.ready;
			@(posedge clk);
		end while (!took);
		beats_sent++;
	endtask

	// a packet of count beats; header and length fields are noise after the first beat
	// with close low the packet is left open and the next start cuts it off
	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] plen,
			input int count, input logic close);
		for (int i = 0; i < count; i++)
			send_beat((i == 0) ? hdr : random_byte(), (i == 0) ? plen : random_byte(),
				random_byte(), i == 0, close && (i == count - 1));
	endtask

	task automatic send_random_traffic();
		int         pick;
		int         size_pick;
		int         count;
		logic [7:0] hdr;
		logic [7:0] plen;
		pick      = $urandom_range(0, 99);
		size_pick = $urandom_range(0, 19);
		hdr       = random_byte();
		// mostly short packets, a few long ones
		if (size_pick < 14)
			count = $urandom_range(1, 6);
		else if (size_pick < 19)
			count = $urandom_range(7, 16);
		else
			count = $urandom_range(17, 40);
		// length field usually honest, sometimes unrelated to the beat count
		plen = ($urandom_range(0, 3) != 0) ? 8'(count) : 8'($urandom_range(1, 249));
		if (pick < 8)
			// beat with no start: payload only, checksums carry on
			send_beat(random_byte(), random_byte(), random_byte(), 1'b0,
				1'($urandom_range(0, 1)));
		else if (pick < 16)
			send_packet(hdr, plen, count, 1'b0);
		else
			send_packet(hdr, plen, count, 1'b1);
	endtask

	// stop sending and wait for every owed frame byte to come out
	task automatic drain_frames();
		cmd_in.valid <= 1'b0;
		do
			@(negedge clk);
		while (bytes_owed != 0);
		@(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_job_mask(input logic [7:0] mask);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mask;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		settings_used++;
	endtask

	// receiver stall pattern: switches between always ready, coin flip,
	// a fixed cadence and long stalls
	initial begin : rx_stall
		rx_mode_t rx_mode;
		int       mode_left;
		int       stall_left;
		frame_out.ready = 1'b0;
		rx_mode         = RX_OPEN;
		mode_left       = 0;
		stall_left      = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (rx_mode)
				RX_OPEN: begin
					frame_out.ready <= 1'b1;
				end
				RX_COIN: begin
					frame_out.ready <= 1'($urandom_range(0, 1));
				end
				RX_PERIODIC: begin
					frame_out.ready <= (mode_left % 3) == 0;
				end
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						frame_out.ready <= 1'b0;
					end else begin
						frame_out.ready <= 1'b1;
						if ($urandom_range(0, 7) == 0)
							stall_left = $urandom_range(1, 12);
					end
				end
			endcase
		end
	end

	// watchdog: too long with no beat moving on either side means a hang
	always @(posedge clk) begin
		if (!arst_n || (cmd_in.valid && cmd_in.ready) || (frame_out.valid && frame_out.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
			$display("asic_command_packet_framer_top test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [7:0] mask_plan [NUM_PHASES];
		int         phase_start;
		arst_n                 = 1'b0;
		cmd_in.valid           = 1'b0;
		cmd_in.header_byte     = 8'h00;
		cmd_in.payload_length  = 8'h00;
		cmd_in.payload_byte    = 8'h00;
		cmd_in.first_of_packet = 1'b0;
		cmd_in.last_of_packet  = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_wr_data            = 8'h00;
		burst_left             = 0;
		beats_sent             = 0;
		idle_cycles            = 0;
		settings_used          = 1;
		// first phase runs on the reset mask, then none, all, random, one bit, back to reset
		mask_plan = '{acpf_pkg::JOB_MASK_RESET, 8'h00, 8'hFF, 8'($urandom_range(1, 254)),
		              8'h80, acpf_pkg::JOB_MASK_RESET};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain_frames();
				write_job_mask(mask_plan[ph]);
			end
			if (ph == 0) begin
				// payload beats before any start: checksums run on from reset
				send_beat(8'h00, 8'h00, 8'hA5, 1'b0, 1'b0);
				// end without a start: checksum of the reset packet type follows
				send_beat(8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1);
				// single-beat job and single-beat command at the field extremes
				send_beat(8'h20, 8'd1, 8'hFF, 1'b1, 1'b1);
				send_beat(8'h00, 8'd249, 8'h00, 1'b1, 1'b1);
				// job with every header bit set, longest length field
				send_packet(8'hFF, 8'd249, 3, 1'b1);
				// command with every bit but the job bit, length field disagrees with count
				send_packet(8'hDF, 8'd1, 2, 1'b1);
				// job left open, then a command starts inside it
				send_packet(8'h20, 8'd5, 2, 1'b0);
				send_packet(8'h01, 8'd3, 3, 1'b1);
				// stray payload between packets, then a packet that ends on its own
				send_beat(8'h5A, 8'hA5, 8'h5A, 1'b0, 1'b0);
				send_packet(8'h3C, 8'd4, 4, 1'b1);
				// end without a start right after a closed packet
				send_beat(8'h00, 8'h00, 8'hC3, 1'b0, 1'b1);
			end
			phase_start = beats_sent;
			while (beats_sent - phase_start < RANDOM_BEATS_PER_PHASE)
				send_random_traffic();
		end

		drain_frames();
		// anything coming out now is a byte nobody owed
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d input beats under %0d job mask settings", beats_sent,
			settings_used);
		$display("summary: %0d frame bytes checked, %0d job and %0d command frames closed",
			bytes_checked, job_frames, cmd_frames);
		if (fail_count == 0)
			$display("asic_command_packet_framer_top test passed");
		else
			$display("asic_command_packet_framer_top test failed");
		$finish;
	end

endmodule
